// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the envelope checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/vea_pkg.sv =====
// ----------------------------------------------------------------------------
// Voice envelope package
// Codes, constants and the sequencer program of the voice envelope block.
// ----------------------------------------------------------------------------
package vea_pkg;

  localparam int LEVEL_W = 23;
  localparam int PC_W    = 3;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL  = LEVEL_W'(127 << 16);
  localparam logic [LEVEL_W-1:0] CUT_DEFAULT = LEVEL_W'(6 << 16);

  // Input modes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;
  localparam logic [1:0] MODE_CUT  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_DECAY   = 3'd1;
  localparam logic [2:0] REG_SUSTAIN = 3'd2;
  localparam logic [2:0] REG_FADE    = 3'd3;
  localparam logic [2:0] REG_RELEASE = 3'd4;
  localparam logic [2:0] REG_INITIAL = 3'd5;

  typedef enum logic [2:0] {
    ST_ATTACK  = 3'd0,
    ST_DECAY   = 3'd1,
    ST_SUSTAIN = 3'd2,
    ST_RELEASE = 3'd3,
    ST_FORCED  = 3'd4
  } stage_t;

  typedef enum logic [2:0] {
    OP_FETCH    = 3'd0,
    OP_MUL_VEL  = 3'd1,
    OP_MUL_CHAN = 3'd2,
    OP_STEP     = 3'd3,
    OP_CMD      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_ALWAYS   = 2'd1,
    COND_NOT_TICK = 2'd2
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Program addresses
  localparam logic [PC_W-1:0] A_FETCH    = PC_W'(0);
  localparam logic [PC_W-1:0] A_MUL_VEL  = PC_W'(1);
  localparam logic [PC_W-1:0] A_MUL_CHAN = PC_W'(2);
  localparam logic [PC_W-1:0] A_STEP     = PC_W'(3);
  localparam logic [PC_W-1:0] A_CMD      = PC_W'(4);

  // A sounding tick runs the two multiplies and the level step; anything else
  // goes straight to the command step.
  function automatic ctrl_t program_rom(input logic [PC_W-1:0] addr);
    ctrl_t w;
    case (addr)
      A_FETCH:    w = '{op: OP_FETCH,    cond: COND_NOT_TICK, target: A_CMD};
      A_MUL_VEL:  w = '{op: OP_MUL_VEL,  cond: COND_NEVER,    target: A_FETCH};
      A_MUL_CHAN: w = '{op: OP_MUL_CHAN, cond: COND_NEVER,    target: A_FETCH};
      A_STEP:     w = '{op: OP_STEP,     cond: COND_ALWAYS,   target: A_FETCH};
      A_CMD:      w = '{op: OP_CMD,      cond: COND_ALWAYS,   target: A_FETCH};
      default:    w = '{op: OP_FETCH,    cond: COND_ALWAYS,   target: A_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/vea_in_if.sv =====
// ----------------------------------------------------------------------------
// Voice envelope input channel
// Valid/ready channel carrying one envelope command or tick.
// ----------------------------------------------------------------------------
interface vea_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [6:0] velocity;
  logic [7:0] channel_level;
  logic       has_channel;

  modport source (output valid, output mode, output velocity, output channel_level,
                  output has_channel, input ready);
  modport sink (input valid, input mode, input velocity, input channel_level,
                input has_channel, output ready);
endinterface

// ===== hdl/vea_out_if.sv =====
// ----------------------------------------------------------------------------
// Voice envelope result channel
// Valid/ready channel carrying the loudness and envelope state of one item.
// ----------------------------------------------------------------------------
interface vea_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  loudness;
  logic [22:0] level;
  logic [2:0]  stage;
  logic        finished;
  logic        voice_active;

  modport source (output valid, output loudness, output level, output stage,
                  output finished, output voice_active, input ready);
  modport sink (input valid, input loudness, input level, input stage,
                input finished, input voice_active, output ready);
endinterface

// ===== hdl/voice_envelope_adsr.sv =====
// ----------------------------------------------------------------------------
// Voice envelope generator
// Envelope level and loudness of one synthesiser voice, run by a small
// microcoded sequencer over a shared multiplier and one add/compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   req carries ticks, note-on, note-off and cut commands; every transfer on
//   req gives exactly one transfer on rsp. The six envelope registers are to
//   be written through cfg_we/cfg_index/cfg_data only while no item is in
//   flight; the block itself does not enforce this. A tick of a sounding
//   voice runs fetch, velocity multiply, channel multiply, then the level
//   step, which loads the result register. The two multiplies share one
//   14x8 multiplier. Commands and ticks of an idle voice run fetch, then the
//   command step. The result register is separate from the sequencer, so
//   the next item is fetched while a result waits; a stalled receiver
//   holds the sequencer only in its final step, until the result register
//   is free. Reset clears the registers to zero and leaves the voice idle
//   in attack.
// ----------------------------------------------------------------------------
module voice_envelope_adsr (
  input  logic              clk,
  input  logic              rst,
  vea_in_if.sink            req,
  vea_out_if.source         rsp,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  localparam int LW = vea_pkg::LEVEL_W;

  // Configuration
  logic [LW-1:0]        attack_step;
  logic [LW-1:0]        decay_step;
  logic [LW-1:0]        sustain_level;
  logic signed [LW:0]   fade_step;
  logic [LW-1:0]        release_step;
  logic [LW-1:0]        initial_level;

  // Voice state
  logic [LW-1:0]        env_level;
  vea_pkg::stage_t      env_stage;
  logic [6:0]           note_vel;
  logic                 sounding;

  // Fetched item and datapath registers
  logic [1:0]           cur_mode;
  logic [6:0]           cur_vel;
  logic [7:0]           cur_chan;
  logic                 cur_has_chan;
  logic [13:0]          prod;
  logic [7:0]           loud;

  logic [vea_pkg::PC_W-1:0] pc;
  logic [vea_pkg::PC_W-1:0] pc_next;
  vea_pkg::ctrl_t       ctrl;

  logic                 out_valid;

  logic [1:0]           in_mode;
  logic                 slot_free;
  logic                 commit;
  logic                 advance;
  logic                 take;

  logic [13:0]          mul_a;
  logic [7:0]           mul_b;
  logic [21:0]          mul_p;

  logic signed [LW+1:0] addend;
  logic signed [LW+1:0] sum;
  logic [LW-1:0]        level_next;
  vea_pkg::stage_t      stage_next;
  logic                 sounding_next;
  logic                 fin_next;
  logic [6:0]           vel_next;
  logic [7:0]           loud_next;

  assign ctrl      = vea_pkg::program_rom(pc);
  assign req.ready = (ctrl.op == vea_pkg::OP_FETCH);
  assign slot_free = !out_valid || rsp.ready;
  assign commit    = (ctrl.op == vea_pkg::OP_STEP || ctrl.op == vea_pkg::OP_CMD) && slot_free;
  assign rsp.valid = out_valid;

  // A note-on with zero velocity is a note-off.
  assign in_mode = (req.mode == vea_pkg::MODE_ON && req.velocity == 7'd0) ?
                   vea_pkg::MODE_OFF : req.mode;

  always_comb begin
    case (ctrl.op)
      vea_pkg::OP_FETCH:                     advance = req.valid;
      vea_pkg::OP_STEP, vea_pkg::OP_CMD:     advance = slot_free;
      default:                               advance = 1'b1;
    endcase
    case (ctrl.cond)
      vea_pkg::COND_ALWAYS:   take = 1'b1;
      vea_pkg::COND_NOT_TICK: take = !(in_mode == vea_pkg::MODE_TICK && sounding);
      default:                take = 1'b0;
    endcase
    if (!advance) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  // Shared multiplier: velocity times whole level, then times channel volume.
  always_comb begin
    if (ctrl.op == vea_pkg::OP_MUL_CHAN) begin
      mul_a = prod;
      mul_b = cur_chan;
    end else begin
      mul_a = {7'd0, env_level[LW-1:16]};
      mul_b = {1'b0, note_vel};
    end
    mul_p = mul_a * mul_b;
  end

  // Level step: one signed add, then the compares of the current stage; the command step applies the fetched command.
  always_comb begin
    case (env_stage)
      vea_pkg::ST_ATTACK:  addend = $signed({2'b00, attack_step});
      vea_pkg::ST_DECAY:   addend = -$signed({2'b00, decay_step});
      vea_pkg::ST_SUSTAIN: addend = -(LW+2)'(fade_step);
      vea_pkg::ST_RELEASE: addend = -$signed({2'b00, release_step});
      vea_pkg::ST_FORCED:  addend = (release_step == '0) ?
                                    -$signed({2'b00, vea_pkg::CUT_DEFAULT}) :
                                    -$signed({2'b00, release_step});
      default:             addend = '0;
    endcase
    sum = $signed({2'b00, env_level}) + addend;

    level_next    = env_level;
    stage_next    = env_stage;
    sounding_next = sounding;
    fin_next      = 1'b0;
    vel_next      = note_vel;
    loud_next     = 8'd0;

    if (ctrl.op == vea_pkg::OP_STEP) begin
      loud_next  = loud;
      level_next = sum[LW-1:0];
      case (env_stage)
        vea_pkg::ST_ATTACK: begin
          if (sum >= $signed({2'b00, vea_pkg::FULL_LEVEL})) begin
            level_next = vea_pkg::FULL_LEVEL;
            stage_next = vea_pkg::ST_DECAY;
          end
        end
        vea_pkg::ST_DECAY: begin
          if (sum <= $signed({2'b00, sustain_level})) begin
            level_next = sustain_level;
            stage_next = vea_pkg::ST_SUSTAIN;
          end
        end
        vea_pkg::ST_SUSTAIN: begin
          if (sum >= $signed({2'b00, vea_pkg::FULL_LEVEL})) begin
            level_next = vea_pkg::FULL_LEVEL;
          end else if (sum <= 0) begin
            level_next = '0;
            fin_next   = 1'b1;
          end
        end
        vea_pkg::ST_RELEASE, vea_pkg::ST_FORCED: begin
          if (sum <= 0) begin
            level_next = '0;
            fin_next   = 1'b1;
          end
        end
        default: level_next = env_level;
      endcase
      if (fin_next) begin
        sounding_next = 1'b0;
      end
    end else begin
      case (cur_mode)
        vea_pkg::MODE_ON: begin
          vel_next      = cur_vel;
          level_next    = initial_level;
          stage_next    = vea_pkg::ST_ATTACK;
          sounding_next = 1'b1;
        end
        vea_pkg::MODE_OFF: begin
          if (sounding) begin
            stage_next = vea_pkg::ST_RELEASE;
          end
        end
        vea_pkg::MODE_CUT: begin
          if (sounding) begin
            stage_next = vea_pkg::ST_FORCED;
          end
        end
        default: stage_next = env_stage;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= vea_pkg::A_FETCH;
      out_valid     <= 1'b0;
      attack_step   <= '0;
      decay_step    <= '0;
      sustain_level <= '0;
      fade_step     <= '0;
      release_step  <= '0;
      initial_level <= '0;
      env_level     <= '0;
      env_stage     <= vea_pkg::ST_ATTACK;
      note_vel      <= '0;
      sounding      <= 1'b0;
    end else begin
      pc <= pc_next;

      if (cfg_we) begin
        case (cfg_index)
          vea_pkg::REG_ATTACK:  attack_step   <= cfg_data[LW-1:0];
          vea_pkg::REG_DECAY:   decay_step    <= cfg_data[LW-1:0];
          vea_pkg::REG_SUSTAIN: sustain_level <= cfg_data[LW-1:0];
          vea_pkg::REG_FADE:    fade_step     <= $signed(cfg_data[LW:0]);
          vea_pkg::REG_RELEASE: release_step  <= cfg_data[LW-1:0];
          vea_pkg::REG_INITIAL: initial_level <= cfg_data[LW-1:0];
          default: ;
        endcase
      end

      // The result register fills on a commit and empties on a transfer.
      out_valid <= commit || (out_valid && !rsp.ready);

      case (ctrl.op)
        vea_pkg::OP_FETCH: begin
          if (req.valid) begin
            cur_mode     <= in_mode;
            cur_vel      <= req.velocity;
            cur_chan     <= req.channel_level;
            cur_has_chan <= req.has_channel;
          end
        end
        vea_pkg::OP_MUL_VEL: begin
          prod <= mul_p[13:0];
        end
        vea_pkg::OP_MUL_CHAN: begin
          loud <= cur_has_chan ? mul_p[21:14] : {1'b0, prod[13:7]};
        end
        vea_pkg::OP_STEP, vea_pkg::OP_CMD: begin
          if (slot_free) begin
            env_level        <= level_next;
            env_stage        <= stage_next;
            sounding         <= sounding_next;
            note_vel         <= vel_next;
            rsp.loudness     <= loud_next;
            rsp.level        <= level_next;
            rsp.stage        <= stage_next;
            rsp.finished     <= fin_next;
            rsp.voice_active <= sounding_next;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/vea_checker.sv =====
// ----------------------------------------------------------------------------
// Voice envelope checker
// Port-level assertions on the result channel of the envelope block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vea_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [7:0]  rsp_loudness,
  input logic [22:0] rsp_level,
  input logic [2:0]  rsp_stage,
  input logic        rsp_finished,
  input logic        rsp_voice_active
);

  logic [35:0] rsp_payload;

  assign rsp_payload = {rsp_loudness, rsp_level, rsp_stage, rsp_finished, rsp_voice_active};

  // A stalled result must be held unchanged.
  `ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

  // A finishing tick leaves the level at zero and the voice idle.
  `ASSERT_IMPLIES(a_fin_zero, clk, rst, rsp_valid && rsp_finished, rsp_level == '0 && !rsp_voice_active)

  // Sound comes only from a tick of a voice that was sounding.
  `ASSERT_IMPLIES(a_loud_active, clk, rst, rsp_valid && rsp_loudness != '0, rsp_voice_active || rsp_finished)

endmodule

bind voice_envelope_adsr vea_port_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_loudness     (rsp.loudness),
  .rsp_level        (rsp.level),
  .rsp_stage        (rsp.stage),
  .rsp_finished     (rsp.finished),
  .rsp_voice_active (rsp.voice_active)
);

// ===== tb/sv/vea_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice envelope checker
// Watches the configuration port and both channels of the voice envelope
// block. It keeps its own copy of the envelope state and registers and works
// out the result of every input transfer. Each result transfer is then
// compared, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module vea_checker
  import vea_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  vea_in_if           req,
  vea_out_if          rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          mismatches,
  output int          in_flight
);

  typedef struct packed {
    logic [7:0]         loudness;
    logic [LEVEL_W-1:0] level;
    stage_t             stage;
    logic               finished;
    logic               voice_active;
  } voice_result_t;

  localparam longint FULL_Q = longint'(FULL_LEVEL);
  localparam longint CUT_Q  = longint'(CUT_DEFAULT);

  // Register copies
  logic [22:0]        attack_rate;
  logic [22:0]        decay_rate;
  logic [22:0]        sustain_lvl;
  logic signed [23:0] fade_rate;
  logic [22:0]        release_rate;
  logic [22:0]        start_level;

  // Voice state
  logic [23:0] env_level;
  stage_t      env_stage;
  logic [6:0]  held_velocity;
  logic        voice_on;

  voice_result_t awaited_results[$];

  function automatic logic [7:0] voice_loudness(logic [7:0] chan, logic with_chan);
    int whole;
    int prod;
    whole = env_level[23:16];
    if (with_chan) begin
      prod = (int'(chan) * int'(held_velocity) * whole) >> 14;
    end else begin
      prod = (int'(held_velocity) * whole) >> 7;
    end
    return prod[7:0];
  endfunction

  // One envelope step of the current stage; returns 1 when the level hits zero.
  function automatic bit step_envelope();
    longint e;
    longint r;
    bit     hit_zero;
    e = env_level;
    hit_zero = 1'b0;
    case (env_stage)
      ST_ATTACK: begin
        e = e + longint'(attack_rate);
        if (e >= FULL_Q) begin
          e = FULL_Q;
          env_stage = ST_DECAY;
        end
      end
      ST_DECAY: begin
        e = e - longint'(decay_rate);
        if (e <= longint'(sustain_lvl)) begin
          e = longint'(sustain_lvl);
          env_stage = ST_SUSTAIN;
        end
      end
      ST_SUSTAIN: begin
        e = e - longint'(fade_rate);
        if (e >= FULL_Q) begin
          e = FULL_Q;
        end else if (e <= 0) begin
          e = 0;
          hit_zero = 1'b1;
        end
      end
      ST_RELEASE, ST_FORCED: begin
        r = longint'(release_rate);
        if (env_stage == ST_FORCED && r == 0) r = CUT_Q;
        e = e - r;
        if (e <= 0) begin
          e = 0;
          hit_zero = 1'b1;
        end
      end
      default: ;
    endcase
    if (e < 0) e = 0;
    env_level = e[23:0];
    return hit_zero;
  endfunction

  function automatic void check_field(string field, logic [22:0] want, logic [22:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    logic [1:0]    op;
    voice_result_t want;
    voice_result_t res;
    if (rst) begin
      attack_rate   = '0;
      decay_rate    = '0;
      sustain_lvl   = '0;
      fade_rate     = '0;
      release_rate  = '0;
      start_level   = '0;
      env_level     = '0;
      env_stage     = ST_ATTACK;
      held_velocity = '0;
      voice_on      = 1'b0;
      awaited_results.delete();
    end else begin
      // Results are matched before this edge's input is predicted, so a result
      // can never be paired with the transfer that arrives alongside it.
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no input outstanding");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("loudness", 23'(want.loudness), 23'(rsp.loudness));
          check_field("level", want.level, rsp.level);
          check_field("stage", 23'(want.stage), 23'(rsp.stage));
          check_field("finished", 23'(want.finished), 23'(rsp.finished));
          check_field("voice_active", 23'(want.voice_active), 23'(rsp.voice_active));
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_ATTACK:  attack_rate  = cfg_data[22:0];
          REG_DECAY:   decay_rate   = cfg_data[22:0];
          REG_SUSTAIN: sustain_lvl  = cfg_data[22:0];
          REG_FADE:    fade_rate    = cfg_data;
          REG_RELEASE: release_rate = cfg_data[22:0];
          REG_INITIAL: start_level  = cfg_data[22:0];
          default: ;
        endcase
      end

      if (req.valid && req.ready) begin
        op = req.mode;
        // A note-on with zero velocity is treated as a note-off.
        if (op == MODE_ON && req.velocity == '0) op = MODE_OFF;
        res.loudness = '0;
        res.finished = 1'b0;
        case (op)
          MODE_TICK: begin
            if (voice_on) begin
              res.loudness = voice_loudness(req.channel_level, req.has_channel);
              res.finished = step_envelope();
              if (res.finished) voice_on = 1'b0;
            end
          end
          MODE_ON: begin
            held_velocity = req.velocity;
            env_level     = {1'b0, start_level};
            env_stage     = ST_ATTACK;
            voice_on      = 1'b1;
          end
          MODE_OFF: begin
            if (voice_on && env_stage != ST_RELEASE) env_stage = ST_RELEASE;
          end
          default: begin
            if (voice_on) env_stage = ST_FORCED;
          end
        endcase
        res.level        = env_level[22:0];
        res.stage        = env_stage;
        res.voice_active = voice_on;
        awaited_results.push_back(res);
      end
    end
    in_flight = awaited_results.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice envelope testbench
// Drives note-on, note-off, cut and tick commands into the voice envelope
// block under a series of register settings, with random gaps on the input
// and random stalls on the result channel. Checking is left to vea_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import vea_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  int          mismatches;
  int          in_flight;
  int          items_sent;
  int          gapless_left;

  vea_in_if  req_ch();
  vea_out_if rsp_ch();

  voice_envelope_adsr dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vea_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap();
    int r;
    if (gapless_left > 0) begin
      gapless_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) gapless_left = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Result side: ready is held for a random number of cycles at a time.
  initial begin
    int r;
    int hold;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          rsp_ch.ready <= 1'b1;
          hold = $urandom_range(40, 150);
        end else if (r < 60) begin
          rsp_ch.ready <= 1'b1;
          hold = $urandom_range(0, 7);
        end else if (r < 92) begin
          rsp_ch.ready <= 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          rsp_ch.ready <= 1'b0;
          hold = $urandom_range(8, 40);
        end
      end
      @(negedge clk);
    end
  end

  // Called and returns at a falling edge; returns once the transfer is done.
  task automatic send(logic [1:0] mode, logic [6:0] vel, logic [7:0] chan, logic with_chan);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.mode          <= mode;
    req_ch.velocity      <= vel;
    req_ch.channel_level <= chan;
    req_ch.has_channel   <= with_chan;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic tick();
    send(MODE_TICK, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
         1'($urandom_range(0, 1)));
  endtask

  task automatic any_item();
    send(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
         1'($urandom_range(0, 1)));
  endtask

  // Holds the input back until every outstanding result has been seen.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic load_config(logic [23:0] atk, logic [23:0] dec, logic [23:0] sus,
                             logic [23:0] fade, logic [23:0] rel, logic [23:0] init);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_DECAY, dec);
    write_reg(REG_SUSTAIN, sus);
    write_reg(REG_FADE, fade);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_INITIAL, init);
    cfg_we <= 1'b0;
  endtask

  // Rates are mostly moderate, so that a note passes through every stage.
  function automatic logic [23:0] pick_rate();
    logic [22:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2:       v = 23'($urandom_range(1, 23'h7FFFFF));
      default: v = 23'($urandom_range(23'h40000, 23'h300000));
    endcase
    // Bit 23 is not part of these registers and must be ignored.
    return {1'($urandom_range(0, 1)), v};
  endfunction

  function automatic logic [23:0] pick_level();
    logic [22:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = FULL_LEVEL;
      2:       v = '1;
      default: v = 23'($urandom_range(0, FULL_LEVEL));
    endcase
    return {1'($urandom_range(0, 1)), v};
  endfunction

  function automatic logic [23:0] pick_fade();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 24'h7FFFFF;
      2:       return 24'h800000;
      3:       return 24'($urandom());
      4, 5:    return 24'(-int'($urandom_range(24'h20000, 24'h200000)));
      default: return 24'($urandom_range(24'h20000, 24'h200000));
    endcase
  endfunction

  // Mostly whole notes (on, ticks, usually an off or a cut, more ticks) with
  // stray items mixed in.
  task automatic run_phase(int quota, bit hold_midway);
    int  target;
    int  midway;
    bit  held;
    int  r;
    logic [6:0] vel;
    target = items_sent + quota;
    midway = items_sent + quota / 2;
    held   = 1'b0;
    while (items_sent < target) begin
      if (hold_midway && !held && items_sent >= midway) begin
        drain();
        held = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        vel = ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
        send(MODE_ON, vel, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 20)) begin
          tick();
          if ($urandom_range(0, 11) == 0) any_item();
        end
        r = $urandom_range(0, 9);
        if (r < 5) begin
          send(MODE_OFF, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
        end else if (r < 8) begin
          send(MODE_CUT, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(1, 15)) tick();
      end else begin
        any_item();
      end
    end
  endtask

  initial begin
    items_sent   = 0;
    gapless_left = 0;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.mode          <= MODE_TICK;
    req_ch.velocity      <= '0;
    req_ch.channel_level <= '0;
    req_ch.has_channel   <= 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Start level above full scale, so the first attack step clamps at once.
    // The large fade empties the sustain stage in one tick.
    load_config(24'h200000, 24'h100000, 24'h400000, 24'h7FFFFF, 24'h000000, 24'h7FFFFF);
    send(MODE_TICK, 7'd127, 8'd255, 1'b1);
    send(MODE_OFF, 7'd0, 8'd0, 1'b0);
    send(MODE_CUT, 7'd127, 8'd255, 1'b1);
    send(MODE_ON, 7'd0, 8'hAA, 1'b1);
    send(MODE_ON, 7'd127, 8'd0, 1'b0);
    send(MODE_TICK, 7'd0, 8'd255, 1'b1);
    send(MODE_TICK, 7'd127, 8'd0, 1'b0);
    send(MODE_TICK, 7'd0, 8'd0, 1'b1);
    send(MODE_TICK, 7'd127, 8'd255, 1'b1);
    send(MODE_TICK, 7'd0, 8'd128, 1'b1);
    send(MODE_TICK, 7'd0, 8'd255, 1'b1);
    send(MODE_TICK, 7'd0, 8'd255, 1'b1);
    send(MODE_ON, 7'd1, 8'd255, 1'b1);
    send(MODE_ON, 7'd64, 8'd1, 1'b0);
    send(MODE_CUT, 7'd0, 8'd0, 1'b0);
    send(MODE_TICK, 7'd0, 8'd200, 1'b1);
    send(MODE_ON, 7'd0, 8'd0, 1'b0);
    send(MODE_TICK, 7'd0, 8'd200, 1'b0);
    send(MODE_OFF, 7'd127, 8'd255, 1'b1);
    drain();

    // Decay lands straight on a sustain level above full scale, and the most
    // negative fade drives the level back up against the clamp.
    load_config(24'h7FFFFF, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h000000);
    send(MODE_ON, 7'd127, 8'd255, 1'b1);
    send(MODE_TICK, 7'd0, 8'd255, 1'b1);
    send(MODE_TICK, 7'd0, 8'd255, 1'b1);
    send(MODE_TICK, 7'd0, 8'd255, 1'b1);
    send(MODE_OFF, 7'd0, 8'd0, 1'b0);
    send(MODE_TICK, 7'd0, 8'd255, 1'b1);
    drain();

    load_config('0, '0, '0, '0, '0, '0);
    run_phase(80, 1'b0);
    drain();

    load_config(24'h7FFFFF, 24'h7FFFFF, {1'b0, FULL_LEVEL}, 24'h7FFFFF, 24'h7FFFFF,
                {1'b0, FULL_LEVEL});
    run_phase(80, 1'b1);
    drain();

    repeat (4) begin
      load_config(pick_rate(), pick_rate(), pick_level(), pick_fade(), pick_rate(),
                  pick_level());
      run_phase(85, 1'b0);
      drain();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/vea_pkg.sv
hdl/vea_in_if.sv
hdl/vea_out_if.sv
hdl/voice_envelope_adsr.sv
hdl/vea_checker.sv
tb/sv/vea_checker.sv
tb/sv/tb_top.sv
